// ===== src/dro_pkg.sv =====
`default_nettype none

package dro_pkg;

  // field widths
  localparam int PHASE_W  = 24;
  localparam int SAMPLE_W = 16;
  localparam int RATIO_W  = 24;
  localparam int DAMP_W   = 24;
  localparam int AMOUNT_W = 16;
  localparam int LEVEL_W  = 17;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_RIPPLE_RATIO  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DAMP_RATE     = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RIPPLE_AMOUNT = 2'd2;

  localparam logic [RATIO_W-1:0]  RIPPLE_RATIO_RESET  = 24'd65536;
  localparam logic [DAMP_W-1:0]   DAMP_RATE_RESET     = 24'd65536;
  localparam logic [AMOUNT_W-1:0] RIPPLE_AMOUNT_RESET = 16'd16384;

  // damping level of 1.0 in unsigned q1.16
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'd65536;

  // entries of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // sine table generation constants
  localparam logic [63:0] Q30_ONE    = 64'd1073741824;
  localparam logic [63:0] TWO_PI_Q29 = 64'd3373259426;

  typedef struct packed {
    logic                       wrap;
    logic [PHASE_W-1:0]         step;
    logic signed [SAMPLE_W-1:0] base;
  } dro_item_t;

  typedef struct packed {
    logic [RATIO_W-1:0]  ripple_ratio;
    logic [DAMP_W-1:0]   damp_rate;
    logic [AMOUNT_W-1:0] ripple_amount;
  } dro_cfg_t;

  // one sine entry from its angle in q0.32 of a turn, taylor series in q2.30
  function automatic logic signed [SAMPLE_W-1:0] sine_entry(input logic [63:0] angle);
    logic [63:0] quad;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] mag;
    quad = (angle >> 30) & 64'd3;
    r    = angle & (Q30_ONE - 64'd1);
    if (quad == 64'd1 || quad == 64'd3) begin
      r = Q30_ONE - r;
    end
    x   = (r * TWO_PI_Q29) >> 31;
    x2  = (x * x) >> 30;
    t   = Q30_ONE - x2 / 64'd110;
    t   = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t   = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t   = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t   = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s   = (x * t) >> 30;
    mag = (s * 64'd32767 + (Q30_ONE >> 1)) >> 30;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    if (quad >= 64'd2) begin
      return -$signed(mag[SAMPLE_W-1:0]);
    end
    return $signed(mag[SAMPLE_W-1:0]);
  endfunction

endpackage

`default_nettype wire

// ===== src/dro_ram.sv =====
`default_nettype none

module dro_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ===== src/dro_table.sv =====
`default_nettype none

module dro_table #(
  parameter int TABLE_LENGTH = 1024
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  output logic                                 busy,
  input  wire logic [$clog2(TABLE_LENGTH)-1:0] addr_a,
  input  wire logic [$clog2(TABLE_LENGTH)-1:0] addr_b,
  output logic signed [dro_pkg::SAMPLE_W-1:0]  data_a,
  output logic signed [dro_pkg::SAMPLE_W-1:0]  data_b
);
  import dro_pkg::*;

  localparam int AW = $clog2(TABLE_LENGTH);
  localparam int CW = $clog2(TABLE_LENGTH + 1);

  logic signed [SAMPLE_W-1:0] sine_rom [TABLE_LENGTH];

  for (genvar g = 0; g < TABLE_LENGTH; g++) begin : g_rom
    localparam logic [63:0] ANGLE = (64'(g) << 32) / 64'(TABLE_LENGTH);
    localparam logic signed [SAMPLE_W-1:0] ENTRY = sine_entry(ANGLE);
    assign sine_rom[g] = ENTRY;
  end

  logic [CW-1:0]       fill_idx;
  logic                fill_we;
  logic [AW-1:0]       fill_addr;
  logic [SAMPLE_W-1:0] fill_data;
  logic [SAMPLE_W-1:0] rd_a;
  logic [SAMPLE_W-1:0] rd_b;

  // fill sweep: one entry a cycle, rom read registered before the write
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_idx <= '0;
      fill_we  <= 1'b0;
      busy     <= 1'b1;
    end else if (fill_idx != CW'(TABLE_LENGTH)) begin
      fill_idx <= fill_idx + 1'b1;
      fill_we  <= 1'b1;
    end else begin
      fill_we <= 1'b0;
      busy    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    fill_addr <= fill_idx[AW-1:0];
    fill_data <= sine_rom[fill_idx[AW-1:0]];
  end

  dro_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(TABLE_LENGTH)
  ) u_ram (
    .clk     (clk),
    .we      (fill_we),
    .waddr   (fill_addr),
    .wdata   (fill_data),
    .raddr_a (addr_a),
    .rdata_a (rd_a),
    .raddr_b (addr_b),
    .rdata_b (rd_b)
  );

  assign data_a = $signed(rd_a);
  assign data_b = $signed(rd_b);

endmodule

`default_nettype wire

// ===== src/dro_front.sv =====
`default_nettype none

module dro_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              accept,
  input  wire logic [dro_pkg::PHASE_W-1:0]       master_phase,
  input  wire logic signed [dro_pkg::SAMPLE_W-1:0] base_sample,
  output dro_pkg::dro_item_t                     item
);
  import dro_pkg::*;

  logic [PHASE_W-1:0] last_master_phase;
  logic               wrap;

  // a phase below the previous one means the master wrapped
  assign wrap       = master_phase < last_master_phase;
  assign item.wrap  = wrap;
  assign item.step  = wrap ? master_phase : master_phase - last_master_phase;
  assign item.base  = base_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_master_phase <= '0;
    end else if (accept) begin
      last_master_phase <= master_phase;
    end
  end

endmodule

`default_nettype wire

// ===== src/dro_queue.sv =====
`default_nettype none

module dro_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire dro_pkg::dro_item_t wr_item,
  output logic                    full,
  input  wire logic               pop,
  output dro_pkg::dro_item_t      rd_item,
  output logic                    valid
);
  import dro_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  dro_item_t       entries [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [NW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full    = count == NW'(QUEUE_DEPTH);
  assign valid   = count != '0;
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rd_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/dro_back.sv =====
`default_nettype none

module dro_back #(
  parameter int TABLE_LENGTH = 1024
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire dro_pkg::dro_cfg_t                 cfg,
  input  wire logic                              q_valid,
  input  wire dro_pkg::dro_item_t                q_item,
  output logic                                   q_pop,
  output logic [$clog2(TABLE_LENGTH)-1:0]        addr_a,
  output logic [$clog2(TABLE_LENGTH)-1:0]        addr_b,
  input  wire logic signed [dro_pkg::SAMPLE_W-1:0] data_a,
  input  wire logic signed [dro_pkg::SAMPLE_W-1:0] data_b,
  output logic                                   out_valid,
  input  wire logic                              out_pop,
  output logic signed [dro_pkg::SAMPLE_W-1:0]    mixed_sample
);
  import dro_pkg::*;

  localparam int AW = $clog2(TABLE_LENGTH);
  localparam int PW = PHASE_W + AW;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MR   = 4'd1;
  localparam logic [3:0] ST_MD   = 4'd2;
  localparam logic [3:0] ST_LVL  = 4'd3;
  localparam logic [3:0] ST_RD   = 4'd4;
  localparam logic [3:0] ST_INT  = 4'd5;
  localparam logic [3:0] ST_SC1  = 4'd6;
  localparam logic [3:0] ST_SC2  = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  logic [3:0]                 state;
  logic [PHASE_W-1:0]         step;
  logic signed [SAMPLE_W-1:0] base;
  logic [PHASE_W-1:0]         ripple_phase;
  logic [LEVEL_W-1:0]         damping_level;
  logic [47:0]                mprod;
  logic [AW-1:0]              idx;
  logic [PHASE_W-1:0]         frac;
  logic signed [SAMPLE_W-1:0] samp_a;
  logic signed [41:0]         iprod;
  logic signed [33:0]         p1;
  logic signed [50:0]         p2;

  logic [PHASE_W-1:0]         mul_b;
  logic [PW-1:0]              pos;
  logic [PHASE_W-1:0]         dec;
  logic signed [16:0]         diff;
  logic signed [17:0]         interp_sum;
  logic signed [SAMPLE_W-1:0] interp;
  logic signed [20:0]         ripple;
  logic signed [21:0]         sum;
  logic signed [SAMPLE_W-1:0] sat;
  logic                       out_free;
  logic                       out_load;

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign out_free = !out_valid || out_pop;
  assign out_load = (state == ST_OUT) && out_free;

  // shared step multiplier: ratio first, then damp rate
  assign mul_b = (state == ST_MR) ? cfg.ripple_ratio : cfg.damp_rate;
  assign dec   = mprod[47:24];
  assign pos   = PW'(ripple_phase) * PW'(TABLE_LENGTH);

  assign addr_a = idx;
  assign addr_b = (idx == AW'(TABLE_LENGTH - 1)) ? '0 : idx + AW'(1);

  // a + (b - a) * f, floored, equals the two-weight interpolation
  assign diff       = 17'(data_b) - 17'(data_a);
  assign interp_sum = 18'(iprod >>> 24) + 18'(samp_a);
  assign interp     = interp_sum[SAMPLE_W-1:0];

  assign ripple = 21'(p2 >>> 30);
  assign sum    = 22'(ripple) + 22'(base);

  always_comb begin
    if (sum > 22'sd32767) begin
      sat = 16'sh7fff;
    end else if (sum < -22'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ripple_phase  <= '0;
      damping_level <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_item.wrap) begin
              ripple_phase  <= '0;
              damping_level <= LEVEL_ONE;
            end
            state <= ST_MR;
          end
        end
        ST_MR: begin
          state <= ST_MD;
        end
        ST_MD: begin
          ripple_phase <= ripple_phase + mprod[39:16];
          state        <= ST_LVL;
        end
        ST_LVL: begin
          if (dec >= PHASE_W'(damping_level)) begin
            damping_level <= '0;
          end else begin
            damping_level <= damping_level - dec[LEVEL_W-1:0];
          end
          state <= ST_RD;
        end
        ST_RD: begin
          state <= ST_INT;
        end
        ST_INT: begin
          state <= ST_SC1;
        end
        ST_SC1: begin
          state <= ST_SC2;
        end
        ST_SC2: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      step <= q_item.step;
      base <= q_item.base;
    end
    if (state == ST_MR || state == ST_MD) begin
      mprod <= 48'(step) * 48'(mul_b);
    end
    if (state == ST_LVL) begin
      idx  <= pos[PW-1:PHASE_W];
      frac <= pos[PHASE_W-1:0];
    end
    if (state == ST_INT) begin
      samp_a <= data_a;
      iprod  <= diff * $signed({1'b0, frac});
    end
    if (state == ST_SC1) begin
      p1 <= interp * $signed({1'b0, damping_level});
    end
    if (state == ST_SC2) begin
      p2 <= p1 * $signed({1'b0, cfg.ripple_amount});
    end
    if (out_load) begin
      mixed_sample <= sat;
    end
  end

endmodule

`default_nettype wire

// ===== src/damped_ripple_oscillator.sv =====
// damped ripple oscillator: each beat on the input queue carries a master phase
// (unsigned q0.24) and a base sample (signed q1.15); each beat on the result queue
// carries the base sample plus a decaying sine ripple, saturated to 16 bits. the
// ripple runs at ripple_ratio times the master rate and restarts at full level
// whenever the master phase goes backwards. after reset the block loads its sine
// table and holds full high meanwhile; configuration writes are taken during that
// time. once running, an item passes in turn through the back sequencer states
// (two passes through the shared step multiplier, a table read and three multiply
// steps), and the sequencer takes no new item until the last one has been loaded
// into its output register; a two-beat queue lets the input side run ahead of it.
`default_nettype none

module damped_ripple_oscillator #(
  parameter int TABLE_LENGTH = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // input queue side
  input  wire logic                                 push,
  output logic                                      full,
  input  wire logic [dro_pkg::PHASE_W-1:0]          master_phase,
  input  wire logic signed [dro_pkg::SAMPLE_W-1:0]  base_sample,
  // result queue side
  output logic                                      empty,
  input  wire logic                                 pop,
  output logic signed [dro_pkg::SAMPLE_W-1:0]       mixed_sample,
  // configuration write port
  input  wire logic                                 cfg_write,
  input  wire logic [dro_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [dro_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import dro_pkg::*;

  localparam int AW = $clog2(TABLE_LENGTH);

  dro_cfg_t  cfg;
  dro_item_t front_item;
  dro_item_t q_item;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;
  logic      table_busy;
  logic      accept;
  logic      out_valid;

  logic [AW-1:0]              addr_a;
  logic [AW-1:0]              addr_b;
  logic signed [SAMPLE_W-1:0] data_a;
  logic signed [SAMPLE_W-1:0] data_b;

  // no items while the sine table is still loading
  assign full   = q_full || table_busy;
  assign accept = push && !full;
  assign empty  = !out_valid;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ripple_ratio  <= RIPPLE_RATIO_RESET;
      cfg.damp_rate     <= DAMP_RATE_RESET;
      cfg.ripple_amount <= RIPPLE_AMOUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RIPPLE_RATIO:  cfg.ripple_ratio  <= cfg_data[RATIO_W-1:0];
        REG_DAMP_RATE:     cfg.damp_rate     <= cfg_data[DAMP_W-1:0];
        REG_RIPPLE_AMOUNT: cfg.ripple_amount <= cfg_data[AMOUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front: wrap detection and phase step, tracks the last master phase
  dro_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .master_phase (master_phase),
    .base_sample  (base_sample),
    .item         (front_item)
  );

  // short queue decoupling the front from the back sequencer
  dro_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (accept),
    .wr_item (front_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (q_item),
    .valid   (q_valid)
  );

  // sine table: filled once after reset, two registered read ports
  dro_table #(
    .TABLE_LENGTH(TABLE_LENGTH)
  ) u_table (
    .clk    (clk),
    .rst    (rst),
    .busy   (table_busy),
    .addr_a (addr_a),
    .addr_b (addr_b),
    .data_a (data_a),
    .data_b (data_b)
  );

  // back: ripple phase and damping state, interpolation, scaling, output beat
  dro_back #(
    .TABLE_LENGTH(TABLE_LENGTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .addr_a       (addr_a),
    .addr_b       (addr_b),
    .data_a       (data_a),
    .data_b       (data_b),
    .out_valid    (out_valid),
    .out_pop      (pop),
    .mixed_sample (mixed_sample)
  );

endmodule

`default_nettype wire
